// ===== design/bxavg_pkg.sv =====
// Shared types, constants and helper functions of the box-average downscaler.
`default_nettype none

package bxavg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_SCALE  = 16;
  localparam int NCHAN      = 3;

  localparam int PIX_W       = 8;
  localparam int DIM_W       = 11;
  localparam int SCALE_W     = 5;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_INDEX_W = 2;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int BLK_W  = $clog2(MAX_SCALE);
  localparam int EXT_W  = ((COL_W > ROW_W) ? COL_W : ROW_W) + 2;
  localparam int HSUM_W = PIX_W + BLK_W;
  localparam int VSUM_W = PIX_W + 2 * BLK_W;
  localparam int AREA_W = 2 * BLK_W + 1;

  localparam int DIV_STEPS = PIX_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_SCALE,
    REG_COLOR_MODE
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ACCUM,
    BK_DIVIDE,
    BK_OUTPUT
  } back_state_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] avg_red;
    logic [PIX_W-1:0] avg_green;
    logic [PIX_W-1:0] avg_blue;
    logic             last_of_frame;
  } result_t;

  typedef logic [NCHAN-1:0][HSUM_W-1:0] hsum_t;
  typedef logic [NCHAN-1:0][VSUM_W-1:0] vsum_t;

  // One completed horizontal block segment, handed from the front to the back.
  typedef struct packed {
    logic             last;
    logic             emit;
    logic             first;
    logic [COL_W-1:0] col;
    hsum_t            hsum;
  } cmd_t;

  function automatic logic [BLK_W:0] clamp_scale(input logic [SCALE_W-1:0] s);
    if (s == '0) begin
      return (BLK_W+1)'(1);
    end else if (int'(s) > MAX_SCALE) begin
      return (BLK_W+1)'(MAX_SCALE);
    end
    return (BLK_W+1)'(s);
  endfunction

  function automatic logic [COL_W:0] clamp_width(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return (COL_W+1)'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      return (COL_W+1)'(MAX_WIDTH);
    end
    return (COL_W+1)'(v);
  endfunction

  function automatic logic [ROW_W:0] clamp_height(input logic [DIM_W-1:0] v);
    if (v == '0) begin
      return (ROW_W+1)'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      return (ROW_W+1)'(MAX_HEIGHT);
    end
    return (ROW_W+1)'(v);
  endfunction

endpackage

`default_nettype wire

// ===== design/bxavg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bxavg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/bxavg_front.sv =====
// Front end: configuration registers, pixel position tracking and horizontal sums.
`default_nettype none

module bxavg_front import bxavg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  pixel_t                 pixel,
  input  logic                   cmd_full,
  output logic                   cmd_push,
  output cmd_t                   cmd,
  output logic [AREA_W-1:0]      area
);

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [SCALE_W-1:0] scale;
  logic               color_mode;

  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [BLK_W-1:0] col_in_blk;
  logic [BLK_W-1:0] row_in_blk;
  logic [COL_W-1:0] out_col;
  hsum_t            hacc;

  logic [COL_W:0]   w_c;
  logic [ROW_W:0]   h_c;
  logic [BLK_W:0]   s_c;
  logic             accept;
  logic             in_cols;
  logic             in_rows;
  logic             in_region;
  logic             col_blk_end;
  logic             row_blk_end;
  logic             row_end;
  logic             frame_end;
  logic             last_block;
  logic [NCHAN-1:0][PIX_W-1:0] px;
  hsum_t            hacc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(640);
      frame_height <= DIM_W'(480);
      scale        <= SCALE_W'(1);
      color_mode   <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_SCALE:        scale        <= cfg_data[SCALE_W-1:0];
        REG_COLOR_MODE:   color_mode   <= cfg_data[0];
      endcase
    end
  end

  assign w_c  = clamp_width(frame_width);
  assign h_c  = clamp_height(frame_height);
  assign s_c  = clamp_scale(scale);
  assign area = AREA_W'(s_c) * AREA_W'(s_c);

  assign accept = push && !cmd_full;
  assign full   = cmd_full;

  // A pixel counts only if the block it belongs to fits wholly inside the frame.
  assign in_cols = (EXT_W'(col_pos) - EXT_W'(col_in_blk) + EXT_W'(s_c)) <= EXT_W'(w_c);
  assign in_rows = (EXT_W'(row_pos) - EXT_W'(row_in_blk) + EXT_W'(s_c)) <= EXT_W'(h_c);
  assign in_region = in_cols && in_rows;

  assign col_blk_end = ({1'b0, col_in_blk} + 1'b1) >= s_c;
  assign row_blk_end = ({1'b0, row_in_blk} + 1'b1) >= s_c;
  assign row_end     = (EXT_W'(col_pos) + 1'b1) >= EXT_W'(w_c);
  assign frame_end   = (EXT_W'(row_pos) + 1'b1) >= EXT_W'(h_c);

  // The last whole block of the frame is the one after which no further block fits.
  assign last_block = ((EXT_W'(col_pos) + 1'b1 + EXT_W'(s_c)) > EXT_W'(w_c)) &&
                      ((EXT_W'(row_pos) + 1'b1 + EXT_W'(s_c)) > EXT_W'(h_c));

  always_comb begin
    px[0] = pixel.red;
    px[1] = color_mode ? pixel.green : '0;
    px[2] = color_mode ? pixel.blue  : '0;
    for (int ch = 0; ch < NCHAN; ch++) begin
      if (col_in_blk == '0) begin
        hacc_next[ch] = HSUM_W'(px[ch]);
      end else begin
        hacc_next[ch] = hacc[ch] + HSUM_W'(px[ch]);
      end
    end
  end

  assign cmd_push   = accept && in_region && col_blk_end;
  assign cmd.last   = last_block;
  assign cmd.emit   = row_blk_end;
  assign cmd.first  = (row_in_blk == '0);
  assign cmd.col    = out_col;
  assign cmd.hsum   = hacc_next;

  always_ff @(posedge clk) begin
    if (accept && in_region) begin
      hacc <= hacc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      col_pos    <= '0;
      row_pos    <= '0;
      col_in_blk <= '0;
      row_in_blk <= '0;
      out_col    <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_pos    <= '0;
        col_in_blk <= '0;
        out_col    <= '0;
        if (frame_end) begin
          row_pos    <= '0;
          row_in_blk <= '0;
        end else begin
          row_pos    <= row_pos + 1'b1;
          row_in_blk <= row_blk_end ? '0 : row_in_blk + 1'b1;
        end
      end else begin
        col_pos <= col_pos + 1'b1;
        if (col_blk_end) begin
          col_in_blk <= '0;
          out_col    <= out_col + 1'b1;
        end else begin
          col_in_blk <= col_in_blk + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bxavg_cmdq.sv =====
// Short queue of block segment commands between the front and back ends.
`default_nettype none

module bxavg_cmdq import bxavg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t din,
  output logic full,
  input  logic pop,
  output cmd_t dout,
  output logic empty
);

  cmd_t                  entries [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_PTR_W:0]   count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/bxavg_back.sv =====
// Back end: column-sum store update, block mean divider and result register.
`default_nettype none

module bxavg_back import bxavg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_empty,
  input  cmd_t              cmd_head,
  output logic              cmd_pop,
  input  logic [AREA_W-1:0] area,
  output logic              empty,
  input  logic              pop,
  output result_t           result
);

  back_state_t state;
  back_state_t state_next;

  cmd_t                  cur;
  logic                  rd_en;
  logic                  wr_en;
  logic                  load_out;
  vsum_t                 rd_data;
  vsum_t                 acc_sum;
  vsum_t                 rem;
  vsum_t                 rem_next;
  logic [NCHAN-1:0]      ge;
  logic [NCHAN-1:0][PIX_W-1:0] quot;
  logic [VSUM_W-1:0]     dshift;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic                  out_valid;

  bxavg_ram #(
    .WIDTH (NCHAN * VSUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_sums (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur.col),
    .wr_data (acc_sum),
    .rd_en   (rd_en),
    .rd_addr (cmd_head.col),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          rd_en      = 1'b1;
          state_next = BK_ACCUM;
        end
      end
      BK_ACCUM: begin
        wr_en      = 1'b1;
        state_next = cur.emit ? BK_DIVIDE : BK_IDLE;
      end
      BK_DIVIDE: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = BK_OUTPUT;
        end
      end
      BK_OUTPUT: begin
        // The result register is free, or its transfer completes in this cycle.
        if (!out_valid || pop) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    for (int ch = 0; ch < NCHAN; ch++) begin
      if (cur.first) begin
        acc_sum[ch] = VSUM_W'(cur.hsum[ch]);
      end else begin
        acc_sum[ch] = rd_data[ch] + VSUM_W'(cur.hsum[ch]);
      end
      ge[ch]       = rem[ch] >= dshift;
      rem_next[ch] = ge[ch] ? rem[ch] - dshift : rem[ch];
    end
  end

  // Restoring division, one quotient bit per cycle; the mean always fits in a pixel.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd_head;
    end
    if (state == BK_ACCUM) begin
      rem     <= acc_sum;
      dshift  <= VSUM_W'(area) << (DIV_STEPS - 1);
      div_cnt <= '0;
      quot    <= '0;
    end else if (state == BK_DIVIDE) begin
      rem     <= rem_next;
      dshift  <= dshift >> 1;
      div_cnt <= div_cnt + 1'b1;
      for (int ch = 0; ch < NCHAN; ch++) begin
        quot[ch] <= {quot[ch][PIX_W-2:0], ge[ch]};
      end
    end
    if (load_out) begin
      result.avg_red       <= quot[0];
      result.avg_green     <= quot[1];
      result.avg_blue      <= quot[2];
      result.last_of_frame <= cur.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== design/box_average_downscaler.sv =====
// Top level of the box-average downscaler.
//
// Pixels arrive in raster order on a queue-style input (push/full) and block
// means leave on a queue-style output (empty/pop). The front end takes one
// pixel per clock for as long as its four-entry command queue has room; it
// issues one command per completed horizontal run of scale pixels. The back
// end reads and then writes the column-sum store for each command and, on
// the last row of a block, also runs the eight-step divider and loads the
// result once the result register is free, so the sustained rate is one
// pixel per clock for scale of two or more on non-final block rows and is
// otherwise set by the back end, which takes no new command until it is
// through with the last one. The column-sum store needs no clearing after
// reset, as the first row of every block overwrites it.
// Any configuration write restarts the frame.
`default_nettype none

module box_average_downscaler import bxavg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   push,
  output logic                   full,
  input  pixel_t                 pixel,
  output logic                   empty,
  input  logic                   pop,
  output result_t                result
);

  logic              cmd_push;
  logic              cmd_full;
  logic              cmd_pop;
  logic              cmd_empty;
  cmd_t              cmd_in;
  cmd_t              cmd_head;
  logic [AREA_W-1:0] area;

  bxavg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .pixel     (pixel),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .area      (area)
  );

  bxavg_cmdq u_cmdq (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_head),
    .empty (cmd_empty)
  );

  bxavg_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .area      (area),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

`default_nettype wire
